// ----- rtl/rdsc_pkg.sv -----
// Shared types, constants and helpers of the radix digit string converter.
`default_nettype none
package rdsc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 7;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int STEP_W     = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_MIN           = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX           = RADIX_W'(16);
	localparam logic [DIGIT_W-1:0] DIGIT_DECIMAL_LIMIT = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  ASCII_ZERO          = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0]  ASCII_UPPER_A       = CHAR_W'(8'h41);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    radix;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} out_beat_t;

	// One classified job as it sits in the queue.
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    radix;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} q_beat_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_DECIMAL_LIMIT) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_UPPER_A + CHAR_W'(d - DIGIT_DECIMAL_LIMIT);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rdsc_front.sv -----
// Front end: accept input beats, clamp the radix and hand jobs to the queue.
`default_nettype none
module rdsc_front (
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  rdsc_pkg::in_beat_t     in_data,
	output rdsc_pkg::q_beat_t      push,
	input  wire logic              full
);

	logic [rdsc_pkg::RADIX_W-1:0] radix_sat;

	// Clamp the radix into the supported band.
	always_comb begin
		if (in_data.radix < rdsc_pkg::RADIX_MIN) begin
			radix_sat = rdsc_pkg::RADIX_MIN;
		end else if (in_data.radix > rdsc_pkg::RADIX_MAX) begin
			radix_sat = rdsc_pkg::RADIX_MAX;
		end else begin
			radix_sat = in_data.radix;
		end
	end

	assign in_ready         = !full;
	assign push.valid       = in_valid && !full;
	assign push.work.value  = in_data.value;
	assign push.work.radix  = radix_sat;

endmodule
`default_nettype wire

// ----- rtl/rdsc_queue.sv -----
// Short job queue between the front end and the conversion engine.
`default_nettype none
module rdsc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  rdsc_pkg::q_beat_t  push,
	output logic               full,
	output rdsc_pkg::q_beat_t  pop,
	input  wire logic          pop_ready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rdsc_pkg::work_t   slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full      = (count_q == CNT_FULL);
	assign pop.valid = (count_q != '0);
	assign pop.work  = slots_q[rd_ptr_q];
	assign do_pop    = pop.valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push.valid) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rdsc_back.sv -----
// Conversion engine: bit-serial division into the digit store, then digit readout.
`default_nettype none
module rdsc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  rdsc_pkg::q_beat_t  pop,
	output logic               pop_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rdsc_pkg::out_beat_t out_data
);

	localparam int VB = rdsc_pkg::VALUE_BITS;
	localparam logic [rdsc_pkg::STEP_W-1:0] STEP_LAST = rdsc_pkg::STEP_W'(VB - 1);
	localparam logic [rdsc_pkg::CNT_W-1:0]  CNT_MAX   = rdsc_pkg::CNT_W'(VB);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_READ = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [VB-1:0]                    quot_q;
	logic [rdsc_pkg::RADIX_W-1:0]     radix_q;
	logic [rdsc_pkg::DIGIT_W-1:0]     rem_q;
	logic [rdsc_pkg::STEP_W-1:0]      step_q;
	logic [rdsc_pkg::CNT_W-1:0]       cnt_q;
	logic [rdsc_pkg::IDX_W-1:0]       rd_idx_q;
	logic [rdsc_pkg::DIGIT_W-1:0]     rd_data_q;
	logic [rdsc_pkg::DIGIT_W-1:0]     digit_store [VB];
	logic                             out_valid_q;
	rdsc_pkg::out_beat_t              out_q;

	logic [rdsc_pkg::RADIX_W-1:0]     rem_sh;
	logic [rdsc_pkg::RADIX_W-1:0]     rem_diff;
	logic                             qbit;
	logic [rdsc_pkg::DIGIT_W-1:0]     rem_nx;
	logic [VB-1:0]                    quot_nx;
	logic                             div_done;
	logic                             slot_free;
	logic                             load_out;

	// One restoring-division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh   = {rem_q, quot_q[VB-1]};
		rem_diff = rem_sh - radix_q;
		qbit     = (rem_sh >= radix_q);
		rem_nx   = qbit ? rem_diff[rdsc_pkg::DIGIT_W-1:0] : rem_sh[rdsc_pkg::DIGIT_W-1:0];
		quot_nx  = {quot_q[VB-2:0], qbit};
	end

	assign div_done  = (state_q == S_DIV) && (step_q == STEP_LAST);
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = (state_q == S_EMIT) && slot_free;
	assign pop_ready = (state_q == S_IDLE);

	// Digit store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (div_done) begin
			digit_store[cnt_q[rdsc_pkg::IDX_W-1:0]] <= rem_nx;
		end
		rd_data_q <= digit_store[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.digit_char <= rdsc_pkg::digit_to_ascii(rd_data_q);
			out_q.last_digit <= (rd_idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			quot_q      <= '0;
			radix_q     <= rdsc_pkg::RADIX_MIN;
			rem_q       <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop.valid) begin
						quot_q  <= pop.work.value;
						radix_q <= pop.work.radix;
						rem_q   <= '0;
						step_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quot_q <= quot_nx;
					if (step_q == STEP_LAST) begin
						// Remainder goes to the store; quotient becomes the next dividend.
						cnt_q  <= cnt_q + rdsc_pkg::CNT_W'(1);
						rem_q  <= '0;
						step_q <= '0;
						if (quot_nx == '0) begin
							rd_idx_q <= cnt_q[rdsc_pkg::IDX_W-1:0];
							state_q  <= S_READ;
						end
					end else begin
						rem_q  <= rem_nx;
						step_q <= step_q + rdsc_pkg::STEP_W'(1);
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						if (rd_idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - rdsc_pkg::IDX_W'(1);
							state_q  <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("digit count overran the store");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rdsc_pkg::RADIX_W'(rem_q) < radix_q))
		else $error("partial remainder not below radix");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (radix_q >= rdsc_pkg::RADIX_MIN && radix_q <= rdsc_pkg::RADIX_MAX))
		else $error("radix out of range during conversion");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && rd_idx_q == '0) |=> (state_q == S_IDLE && out_data.last_digit))
		else $error("final digit did not close the job");

endmodule
`default_nettype wire

// ----- rtl/radix_digit_string_converter.sv -----
// Top level of the radix digit string converter.
`default_nettype none
// Converts a non-negative 31-bit value to ASCII digits in a radix of 2 to 16
// ('0'-'9', then 'A'-'F'), most significant digit first, one output beat per
// digit; the final digit carries last_digit. A zero value gives the single
// digit '0'. Radix codes below 2 are clamped to 2, above 16 to 16. The front
// end takes an input beat whenever the job queue (QUEUE_DEPTH entries) has
// room, so new jobs are accepted while the engine is still busy. The engine
// works one job at a time: each digit costs one pass of a bit-serial restoring
// divider, then the digit is read back out of the store (S_READ) and loaded
// into the output register (S_EMIT). While out_ready holds the output off,
// the engine waits in S_EMIT. The output register lets the engine pick up the
// next job while the final digit still waits.
module radix_digit_string_converter #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  rdsc_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rdsc_pkg::out_beat_t out_data
);

	rdsc_pkg::q_beat_t push;
	rdsc_pkg::q_beat_t pop;
	logic              q_full;
	logic              pop_ready;

	// Accept and clamp.
	rdsc_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.full     (q_full)
	);

	// Decouple intake from the engine.
	rdsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop       (pop),
		.pop_ready (pop_ready)
	);

	// Divide, store remainders, emit digits.
	rdsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_ready (pop_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
